// File: rtl/ite_pkg.sv
package ite_pkg;

    localparam int unsigned ENTRIES_DEFAULT = 64;
    localparam int unsigned KEY_W           = 64;
    localparam int unsigned TIME_W          = 32;
    localparam int unsigned CODE_W          = 3;

    localparam logic [TIME_W-1:0] MAX_COLD_RESET = TIME_W'(3600);

    localparam logic ACT_TOUCH = 1'b0;
    localparam logic ACT_SWEEP = 1'b1;

    localparam logic [CODE_W-1:0] CODE_UPDATED  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_INSERTED = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DROPPED  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_EVICTED  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_NONE     = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [KEY_W-1:0]  wr_key;
        logic [TIME_W-1:0] wr_time;
        logic              rd_en;
    } mem_req_t;

endpackage

// File: rtl/ite_store.sv
module ite_store
    import ite_pkg::*;
#(
    parameter int unsigned DEPTH = ENTRIES_DEFAULT,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  mem_req_t          req,
    input  logic [AW-1:0]     wr_addr,
    input  logic [AW-1:0]     rd_addr,
    output logic [KEY_W-1:0]  rd_key,
    output logic [TIME_W-1:0] rd_time
);

    logic [KEY_W-1:0]  key_mem  [DEPTH];
    logic [TIME_W-1:0] time_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            key_mem[wr_addr]  <= req.wr_key;
            time_mem[wr_addr] <= req.wr_time;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_key  <= key_mem[rd_addr];
            rd_time <= time_mem[rd_addr];
        end
    end

endmodule

// File: rtl/ite_ctrl.sv
module ite_ctrl
    import ite_pkg::*;
#(
    parameter int unsigned DEPTH = ENTRIES_DEFAULT,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              action,
    input  logic [KEY_W-1:0]  key,
    input  logic [TIME_W-1:0] now_secs,
    input  logic              cfg_we,
    input  logic [TIME_W-1:0] max_cold_secs,
    output logic              result_valid,
    output logic [CODE_W-1:0] code,
    output logic [KEY_W-1:0]  out_key,
    output logic              last,
    output mem_req_t          req,
    output logic [AW-1:0]     wr_addr,
    output logic [AW-1:0]     rd_addr,
    input  logic [KEY_W-1:0]  rd_key,
    input  logic [TIME_W-1:0] rd_time
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    state_t            state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [AW-1:0]     chk_idx_reg, chk_idx_next;
    logic [DEPTH-1:0]  valid_reg, valid_next;
    logic [TIME_W-1:0] max_cold_reg, max_cold_next;
    logic              act_reg, act_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              hit_reg, hit_next;
    logic [AW-1:0]     hit_idx_reg, hit_idx_next;
    logic              free_reg, free_next;
    logic [AW-1:0]     free_idx_reg, free_idx_next;
    logic              pend_reg, pend_next;
    logic [KEY_W-1:0]  pend_key_reg, pend_key_next;
    logic              res_vld_reg, res_vld_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic              last_reg, last_next;
    logic [TIME_W-1:0] idle;
    logic              chk_slot_vld;

    assign idle         = now_reg - rd_time;
    assign chk_slot_vld = valid_reg[chk_idx_reg];

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = idx_reg;
        valid_next    = valid_reg;
        max_cold_next = cfg_we ? max_cold_secs : max_cold_reg;
        act_next      = act_reg;
        key_next      = key_reg;
        now_next      = now_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        pend_next     = pend_reg;
        pend_key_next = pend_key_reg;
        res_vld_next  = 1'b0;
        code_next     = code_reg;
        out_key_next  = out_key_reg;
        last_next     = last_reg;
        req.wr_en     = 1'b0;
        req.wr_key    = key_reg;
        req.wr_time   = now_reg;
        req.rd_en     = 1'b0;
        wr_addr       = hit_reg ? hit_idx_reg : free_idx_reg;
        rd_addr       = idx_reg;

        if (chk_vld_reg)
        begin
            if (act_reg == ACT_TOUCH)
            begin
                if (chk_slot_vld && !hit_reg && (rd_key == key_reg))
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = chk_idx_reg;
                end
                if (!chk_slot_vld && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = chk_idx_reg;
                end
            end
            else if (chk_slot_vld && (idle > max_cold_reg))
            begin
                valid_next[chk_idx_reg] = 1'b0;
                if (pend_reg)
                begin
                    res_vld_next = 1'b1;
                    code_next    = CODE_EVICTED;
                    out_key_next = pend_key_reg;
                    last_next    = 1'b0;
                end
                pend_next     = 1'b1;
                pend_key_next = rd_key;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    key_next   = key;
                    now_next   = now_secs;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    pend_next  = 1'b0;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                req.rd_en    = 1'b1;
                chk_vld_next = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_vld_next = 1'b1;
                last_next    = 1'b1;
                state_next   = ST_IDLE;
                if (act_reg == ACT_TOUCH)
                begin
                    out_key_next = key_reg;
                    if (hit_reg)
                    begin
                        req.wr_en = 1'b1;
                        code_next = CODE_UPDATED;
                    end
                    else if (free_reg)
                    begin
                        req.wr_en                = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                        code_next                = CODE_INSERTED;
                    end
                    else
                    begin
                        code_next = CODE_DROPPED;
                    end
                end
                else if (pend_reg)
                begin
                    code_next    = CODE_EVICTED;
                    out_key_next = pend_key_reg;
                end
                else
                begin
                    code_next    = CODE_NONE;
                    out_key_next = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            valid_reg    <= '0;
            max_cold_reg <= MAX_COLD_RESET;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            chk_vld_reg  <= chk_vld_next;
            valid_reg    <= valid_next;
            max_cold_reg <= max_cold_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            pend_reg     <= pend_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        act_reg      <= act_next;
        key_reg      <= key_next;
        now_reg      <= now_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        pend_key_reg <= pend_key_next;
        code_reg     <= code_next;
        out_key_reg  <= out_key_next;
        last_reg     <= last_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_vld_reg;
    assign code         = code_reg;
    assign out_key      = out_key_reg;
    assign last         = last_reg;

endmodule

// File: rtl/idle_time_key_evictor.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+-------------------------------
// item in   | start & !busy           | action, key, now_secs
// result    | result_valid, one cycle | code, out_key, last
// config    | cfg_we                  | max_cold_secs
//
// Busy stays high from an accepted input transaction through the scan, wait and done states;
// no new input transaction is accepted until it falls.
// The controller walks the key and timestamp memory one slot per cycle through its read port.
// Reset clears the valid bits of all slots at once and loads max_cold_secs with 3600.
// Results appear for a single cycle each; the receiver cannot stall them.
module idle_time_key_evictor
    import ite_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              action,
    input  logic [KEY_W-1:0]  key,
    input  logic [TIME_W-1:0] now_secs,
    input  logic              cfg_we,
    input  logic [TIME_W-1:0] max_cold_secs,
    output logic              result_valid,
    output logic [CODE_W-1:0] code,
    output logic [KEY_W-1:0]  out_key,
    output logic              last
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    mem_req_t          req;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [KEY_W-1:0]  rd_key;
    logic [TIME_W-1:0] rd_time;

    ite_ctrl #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .key           (key),
        .now_secs      (now_secs),
        .cfg_we        (cfg_we),
        .max_cold_secs (max_cold_secs),
        .result_valid  (result_valid),
        .code          (code),
        .out_key       (out_key),
        .last          (last),
        .req           (req),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .rd_key        (rd_key),
        .rd_time       (rd_time)
    );

    ite_store #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .req     (req),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_time (rd_time)
    );

endmodule

// File: tb/idle_time_key_evictor_tb.sv
module idle_time_key_evictor_tb;
    import ite_pkg::*;

    localparam int unsigned SLOTS      = ENTRIES_DEFAULT;
    localparam int unsigned POOL_SIZE  = 96;
    localparam int unsigned QUIET_MAX  = 4000;
    localparam int unsigned NUM_ROWS   = 12;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic [KEY_W-1:0]  out_key;
        logic              last;
    } evictor_result_t;

    typedef struct {
        logic              act;
        logic [KEY_W-1:0]  id;
        logic [TIME_W-1:0] stamp;
        logic              pinned;
        logic [CODE_W-1:0] pin_code;
        logic [KEY_W-1:0]  pin_key;
    } directed_item_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              action;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now_secs;
    logic              cfg_we;
    logic [TIME_W-1:0] max_cold_secs;
    logic              result_valid;
    logic [CODE_W-1:0] code;
    logic [KEY_W-1:0]  out_key;
    logic              last;

    logic              pin_en;
    logic [CODE_W-1:0] pin_code;
    logic [KEY_W-1:0]  pin_key;

    logic              held [SLOTS];
    logic [KEY_W-1:0]  held_key [SLOTS];
    logic [TIME_W-1:0] held_stamp [SLOTS];
    logic [TIME_W-1:0] cold_limit;

    evictor_result_t   pending_results [$];
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];
    logic [TIME_W-1:0] wall_secs;

    int                sender_idle_pct;
    int                error_count;
    int                items_taken;
    int                results_seen;
    int                evictions;
    int                drops;
    int                empty_sweeps;
    int                quiet_cycles;

    directed_item_t directed_rows [NUM_ROWS] = '{
        '{ACT_SWEEP, 64'h0, 32'd0, 1'b1, CODE_NONE, 64'h0},
        '{ACT_TOUCH, 64'h0, 32'd0, 1'b1, CODE_INSERTED, 64'h0},
        '{ACT_TOUCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, CODE_INSERTED,
          64'hFFFF_FFFF_FFFF_FFFF},
        '{ACT_TOUCH, 64'h0, 32'd100, 1'b1, CODE_UPDATED, 64'h0},
        '{ACT_TOUCH, 64'h8000_0000_0000_0000, 32'd5, 1'b1, CODE_INSERTED,
          64'h8000_0000_0000_0000},
        '{ACT_TOUCH, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b1, CODE_INSERTED,
          64'h5555_5555_5555_5555},
        '{ACT_TOUCH, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b1, CODE_INSERTED,
          64'hAAAA_AAAA_AAAA_AAAA},
        '{ACT_SWEEP, 64'h1234_5678_9ABC_DEF0, 32'd3700, 1'b0, CODE_NONE, 64'h0},
        '{ACT_SWEEP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd3701, 1'b1, CODE_EVICTED, 64'h0},
        '{ACT_SWEEP, 64'h0, 32'd3701, 1'b1, CODE_NONE, 64'h0},
        '{ACT_TOUCH, 64'h1, 32'h10, 1'b1, CODE_INSERTED, 64'h1},
        '{ACT_SWEEP, 64'h0, 32'h5, 1'b1, CODE_EVICTED, 64'h1}
    };

    idle_time_key_evictor #(
        .TABLE_ENTRIES(SLOTS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .key          (key),
        .now_secs     (now_secs),
        .cfg_we       (cfg_we),
        .max_cold_secs(max_cold_secs),
        .result_valid (result_valid),
        .code         (code),
        .out_key      (out_key),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic queue_result(input evictor_result_t res);
        pending_results.insert(pending_results.size(), res);
    endtask

    task automatic predict_table_step(input logic act, input logic [KEY_W-1:0] id,
                                      input logic [TIME_W-1:0] stamp);
        int hit;
        int vacant;
        int evicted;
        logic [TIME_W-1:0] idle;
        evictor_result_t tail;
        hit = -1;
        vacant = -1;
        evicted = 0;
        if (act == ACT_TOUCH)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (held[i])
                begin
                    if (hit < 0 && held_key[i] == id)
                        hit = i;
                end
                else if (vacant < 0)
                begin
                    vacant = i;
                end
            end
            if (hit >= 0)
            begin
                held_stamp[hit] = stamp;
                queue_result('{CODE_UPDATED, id, 1'b1});
            end
            else if (vacant >= 0)
            begin
                held[vacant] = 1'b1;
                held_key[vacant] = id;
                held_stamp[vacant] = stamp;
                queue_result('{CODE_INSERTED, id, 1'b1});
            end
            else
            begin
                queue_result('{CODE_DROPPED, id, 1'b1});
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (held[i])
                begin
                    idle = stamp - held_stamp[i];
                    if (idle > cold_limit)
                    begin
                        queue_result('{CODE_EVICTED, held_key[i], 1'b0});
                        held[i] = 1'b0;
                        evicted++;
                    end
                end
            end
            if (evicted == 0)
            begin
                queue_result('{CODE_NONE, '0, 1'b1});
            end
            else
            begin
                tail = pending_results.pop_back();
                tail.last = 1'b1;
                queue_result(tail);
            end
        end
    endtask

    always @(posedge clk)
    begin : monitor
        evictor_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                held[i] = 1'b0;
            cold_limit = MAX_COLD_RESET;
            pending_results.delete();
            quiet_cycles = 0;
        end
        else
        begin
            if (result_valid)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result code %0d key %h last %b",
                                              code, out_key, last));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (code !== want.code)
                        report_mismatch($sformatf("code %0d, expected %0d", code, want.code));
                    if (out_key !== want.out_key)
                        report_mismatch($sformatf("out_key %h, expected %h",
                                                  out_key, want.out_key));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b", last, want.last));
                    if (want.code == CODE_EVICTED)
                        evictions++;
                    else if (want.code == CODE_DROPPED)
                        drops++;
                    else if (want.code == CODE_NONE)
                        empty_sweeps++;
                end
            end
            if (cfg_we)
                cold_limit = max_cold_secs;
            if (start && !busy)
            begin
                items_taken++;
                predict_table_step(action, key, now_secs);
                if (pin_en)
                begin
                    void'(pending_results.pop_back());
                    queue_result('{pin_code, pin_key, 1'b1});
                end
            end
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("Timeout: no transaction for %0d cycles", QUIET_MAX);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic act, input logic [KEY_W-1:0] id,
                             input logic [TIME_W-1:0] stamp, input logic pinned,
                             input logic [CODE_W-1:0] want_code,
                             input logic [KEY_W-1:0] want_key);
        int gap;
        gap = 0;
        if (sender_idle_pct > 0 && $urandom_range(7) == 0)
            gap = $urandom_range(90, 1);
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        action   <= act;
        key      <= id;
        now_secs <= stamp;
        pin_en   <= pinned;
        pin_code <= want_code;
        pin_key  <= want_key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0 || busy);
        @(posedge clk);
    endtask

    task automatic set_cold_limit(input logic [TIME_W-1:0] limit);
        wait_drained();
        cfg_we        <= 1'b1;
        max_cold_secs <= limit;
        @(posedge clk);
        cfg_we        <= 1'b0;
    endtask

    task automatic random_items(input int count, input int sweep_pct,
                                input int unsigned jump_max);
        logic              act;
        logic [KEY_W-1:0]  id;
        int                pick;
        for (int j = 0; j < count; j++)
        begin
            act = ($urandom_range(99) < sweep_pct) ? ACT_SWEEP : ACT_TOUCH;
            if ($urandom_range(9) < 8)
                id = key_pool[$urandom_range(POOL_SIZE - 1)];
            else
                id = {$urandom, $urandom};
            pick = $urandom_range(99);
            if (pick < 4)
                wall_secs = $urandom;
            else if (pick < 10)
                wall_secs = wall_secs - $urandom_range(jump_max);
            else
                wall_secs = wall_secs + $urandom_range(jump_max);
            send_item(act, id, wall_secs, 1'b0, CODE_NONE, '0);
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        start         <= 1'b0;
        action        <= ACT_TOUCH;
        key           <= '0;
        now_secs      <= '0;
        cfg_we        <= 1'b0;
        max_cold_secs <= '0;
        pin_en        <= 1'b0;
        pin_code      <= CODE_NONE;
        pin_key       <= '0;
        error_count   = 0;
        items_taken   = 0;
        results_seen  = 0;
        evictions     = 0;
        drops         = 0;
        empty_sweeps  = 0;
        wall_secs     = 32'd1000;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        key_pool[3] = 64'h1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 26;
        foreach (directed_rows[r])
            send_item(directed_rows[r].act, directed_rows[r].id, directed_rows[r].stamp,
                      directed_rows[r].pinned, directed_rows[r].pin_code,
                      directed_rows[r].pin_key);

        // With the largest limit nothing goes cold, so the table fills and touches drop.
        set_cold_limit(32'hFFFF_FFFF);
        random_items(90, 10, 500);
        set_cold_limit(32'd0);
        random_items(10, 50, 3);

        sender_idle_pct = 79;
        set_cold_limit($urandom_range(3000, 100));
        random_items(80, 20, 600);

        sender_idle_pct = 0;
        set_cold_limit($urandom);
        random_items(40, 20, 32'h4000_0000);
        set_cold_limit(32'd1);
        random_items(25, 30, 3);

        wait_drained();
        repeat (SLOTS + 8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));

        $display("Ran %0d transactions in and %0d results out: %0d evictions, %0d drops,",
                 items_taken, results_seen, evictions, drops);
        $display("%0d empty sweeps; cold limits reset, 0, 1, max, random; idle 26%%, 79%%, 0%%.",
                 empty_sweeps);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/ite_pkg.sv
rtl/ite_store.sv
rtl/ite_ctrl.sv
rtl/idle_time_key_evictor.sv
tb/idle_time_key_evictor_tb.sv
